FILE: design/fpexp2_pkg.sv
package fpexp2_pkg;

   // log_value layout: integer part above the fraction
   localparam int FRACTION_BITS    = 32;
   localparam int LOG_WIDTH        = 38;
   localparam int INT_WIDTH        = LOG_WIDTH - FRACTION_BITS;
   localparam int POWER_WIDTH      = 64;
   localparam int REQ_TDATA_WIDTH  = ((LOG_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH  = ((POWER_WIDTH + 7) / 8) * 8;
   localparam int INT_BITS_DEFAULT = 6;

   // Horner chain for 2^f - 1 in Q0.32; entry 0 seeds the accumulator
   localparam int HORNER_STEPS = 6;
   localparam logic [FRACTION_BITS-1:0] HORNER_COEF [0:HORNER_STEPS] = '{
      32'h000e5867,
      32'h00512969,
      32'h027ab6f0,
      32'h0e33f3a6,
      32'h3d7fbfd4,
      32'hb17213ac,
      32'h0000000b
   };

   // final correction, adds -1 modulo 2^32
   localparam logic [FRACTION_BITS-1:0] POLY_CORRECTION = 32'hffffffff;

   typedef struct packed {
      logic [FRACTION_BITS-1:0] acc;
      logic [FRACTION_BITS-1:0] frac;
      logic [INT_WIDTH-1:0]     exponent;
   } pipe_type;

endpackage

FILE: design/fpexp2_horner_stage.sv
// One Horner step: acc = hi32(acc * frac) + coef, registered.
module fpexp2_horner_stage (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  fpexp2_pkg::pipe_type                   in_data,
   input  logic [fpexp2_pkg::FRACTION_BITS-1:0]   coef,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output fpexp2_pkg::pipe_type                   out_data
);

   logic                                       valid_ff;
   fpexp2_pkg::pipe_type                       data_ff;
   fpexp2_pkg::pipe_type                       data_in;
   logic [2*fpexp2_pkg::FRACTION_BITS-1:0]     product;
   logic                                       load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      product = {{fpexp2_pkg::FRACTION_BITS{1'b0}}, in_data.acc}
              * {{fpexp2_pkg::FRACTION_BITS{1'b0}}, in_data.frac};
      data_in          = in_data;
      data_in.acc      = product[2*fpexp2_pkg::FRACTION_BITS-1:fpexp2_pkg::FRACTION_BITS]
                       + coef;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: design/fpexp2_scale_stage.sv
// Correction, mantissa build and shift by the integer part; output register.
module fpexp2_scale_stage #(
   parameter int INT_BITS = fpexp2_pkg::INT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  fpexp2_pkg::pipe_type                  in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [fpexp2_pkg::POWER_WIDTH-1:0]    out_power
);

   localparam int FB      = fpexp2_pkg::FRACTION_BITS;
   localparam int IW      = fpexp2_pkg::INT_WIDTH;
   localparam int PW      = fpexp2_pkg::POWER_WIDTH;
   localparam int SHIFT_W = FB + 1 + (1 << IW) - 1;
   localparam logic [IW:0] INT_LIMIT = (IW + 1)'((1 << INT_BITS) - 1);

   logic                     valid_ff;
   logic [PW-1:0]            power_ff;
   logic [PW-1:0]            power_in;
   logic [FB-1:0]            poly;
   logic [FB:0]              mant;
   logic [SHIFT_W-1:0]       shifted;
   logic                     saturate;
   logic                     load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      // zero fraction is exact: 2^0 - 1 = 0
      poly     = (in_data.frac == '0) ? '0 : in_data.acc + fpexp2_pkg::POLY_CORRECTION;
      mant     = {1'b1, poly};
      shifted  = {{(SHIFT_W-FB-1){1'b0}}, mant} << in_data.exponent;
      saturate = {1'b0, in_data.exponent} > INT_LIMIT;
      power_in = saturate ? '1 : PW'(shifted[SHIFT_W-1:FB]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         power_ff <= power_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_power = power_ff;

   // mantissa is at least one unit, so a result is never zero
   a_power_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> power_ff != '0)
      else $error("fpexp2 scale: zero result");

   // zero fraction in range gives an exact power of two
   a_zero_frac_exact: assert property (@(posedge clock) disable iff (reset)
      (load && in_data.frac == '0 && !saturate) |=> $onehot(power_ff))
      else $error("fpexp2 scale: zero fraction not a power of two");

endmodule

FILE: design/fixed_point_exp2_unit.sv
// Channel  Dir  Bits  Payload (tdata, low bit up)
// req      in   40    log_value[37:0] (31:0 fraction, 37:32 integer part), zero pad
// rsp      out  64    power_value[63:0]
//
// Throughput: one transaction per clock, back to back, while rsp_tready stays high.
// Pipeline: six Horner multiply-add stages, one 32x32 multiplier each, then
//   the correction/shift output register.
// Reset: synchronous, active high; clears only the stage valid bits.
// Stalls: each stage holds while its successor is full and stalled; empty
//   stages still fill, so req_tready stays high until the whole chain is full.
module fixed_point_exp2_unit #(
   parameter int INT_BITS = fpexp2_pkg::INT_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // log_value[37:0], zero padded
   input  logic [fpexp2_pkg::REQ_TDATA_WIDTH-1:0]    req_tdata,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // power_value[63:0]
   output logic [fpexp2_pkg::RSP_TDATA_WIDTH-1:0]    rsp_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready
);

   localparam int STEPS = fpexp2_pkg::HORNER_STEPS;
   localparam int FB    = fpexp2_pkg::FRACTION_BITS;

   // index 0 is the input side, index STEPS feeds the scale stage
   fpexp2_pkg::pipe_type  stage_data  [0:STEPS];
   logic [STEPS:0]        stage_valid;
   logic [STEPS:0]        stage_ready;
   logic [fpexp2_pkg::POWER_WIDTH-1:0] power;

   // seed the accumulator with the leading coefficient
   always_comb begin
      stage_data[0].acc      = fpexp2_pkg::HORNER_COEF[0];
      stage_data[0].frac     = req_tdata[FB-1:0];
      stage_data[0].exponent = req_tdata[fpexp2_pkg::LOG_WIDTH-1:FB];
   end
   assign stage_valid[0] = req_tvalid;
   assign req_tready     = stage_ready[0];

   for (genvar i = 0; i < STEPS; i++) begin : g_horner
      fpexp2_horner_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .coef      (fpexp2_pkg::HORNER_COEF[i+1]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   fpexp2_scale_stage #(
      .INT_BITS (INT_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[STEPS]),
      .in_ready  (stage_ready[STEPS]),
      .in_data   (stage_data[STEPS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_power (power)
   );

   assign rsp_tdata = fpexp2_pkg::RSP_TDATA_WIDTH'(power);

   // an accepted transaction always lands in the first Horner stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> stage_valid[1])
      else $error("fpexp2: accepted transaction lost at stage 1");

   // a completely full, stalled chain must push back on the input
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (&stage_valid[STEPS:1] && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("fpexp2: input accepted into a full stalled pipeline");

endmodule

FILE: dv/fixed_point_exp2_unit_tb.sv
module fixed_point_exp2_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRACTION_BITS   = fpexp2_pkg::FRACTION_BITS;
   localparam int LOG_WIDTH       = fpexp2_pkg::LOG_WIDTH;
   localparam int INT_WIDTH       = fpexp2_pkg::INT_WIDTH;
   localparam int POWER_WIDTH     = fpexp2_pkg::POWER_WIDTH;
   localparam int REQ_TDATA_WIDTH = fpexp2_pkg::REQ_TDATA_WIDTH;
   localparam int RSP_TDATA_WIDTH = fpexp2_pkg::RSP_TDATA_WIDTH;

   localparam int INT_BITS     = fpexp2_pkg::INT_BITS_DEFAULT;
   // pipeline depth from the block header, plus margin for the drain
   localparam int PIPE_LATENCY = 7;
   localparam int DRAIN_CYCLES = 4 * PIPE_LATENCY;
   // leaves a wide margin for ~1700 transactions under 60% stalls
   localparam int CYCLE_LIMIT  = 200000;
   localparam int ITEMS_PER_PHASE = 567;
   localparam int DIR_ROWS     = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;

   // idle percentages for each side, changed per phase
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;

   int unsigned cycle_count   = 0;
   int unsigned mismatches    = 0;

   // power values still owed by the block, oldest first
   logic [POWER_WIDTH-1:0] pending_power [$];

   fixed_point_exp2_unit #(
      .INT_BITS(INT_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // 2^f - 1 in Q0.32: Horner chain on the high half of each 32x32 product,
   // every add wrapping at 32 bits. Zero fraction short-circuits to zero.
   function automatic logic [FRACTION_BITS-1:0] frac_exp2_m1(
      input logic [FRACTION_BITS-1:0] frac
   );
      logic [FRACTION_BITS-1:0]   acc;
      logic [2*FRACTION_BITS-1:0] prod;
      if (frac == '0)
         return '0;
      acc = fpexp2_pkg::HORNER_COEF[0];
      for (int k = 1; k <= fpexp2_pkg::HORNER_STEPS; k++) begin
         prod = {{FRACTION_BITS{1'b0}}, acc} * {{FRACTION_BITS{1'b0}}, frac};
         acc  = prod[2*FRACTION_BITS-1:FRACTION_BITS] + fpexp2_pkg::HORNER_COEF[k];
      end
      return acc + fpexp2_pkg::POLY_CORRECTION;
   endfunction

   // ((2^32 + p(f)) << n) >> 32, saturating when n is beyond the bound
   function automatic logic [POWER_WIDTH-1:0] exp2_power(
      input logic [LOG_WIDTH-1:0] log_value
   );
      logic [POWER_WIDTH-1:0] mant;
      int unsigned            n;
      n = 32'(log_value[LOG_WIDTH-1:FRACTION_BITS]);
      if (n > (1 << INT_BITS) - 1)
         return '1;
      mant = (64'd1 << FRACTION_BITS)
           + {32'd0, frac_exp2_m1(log_value[FRACTION_BITS-1:0])};
      if (n >= FRACTION_BITS)
         return mant << (n - FRACTION_BITS);
      return mant >> (FRACTION_BITS - n);
   endfunction

   // ------------------------------------------------------------------
   // Request side: called at a falling edge, returns at a falling edge
   // ------------------------------------------------------------------
   task automatic send_log(
      input logic [LOG_WIDTH-1:0]   log_value,
      input logic [POWER_WIDTH-1:0] power_value
   );
      // random gaps before the transaction
      while (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_WIDTH-LOG_WIDTH){1'b0}}, log_value};
      do
         @(posedge clock);
      while (!req_tready);
      pending_power.push_back(power_value);
      @(negedge clock);
   endtask

   // hold the request side quiet until every owed result has come back
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (pending_power.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random backpressure, checked at the rising edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_power.size() == 0) begin
            $error("power_value: no transaction expected, actual %h", rsp_tdata);
            mismatches++;
         end else begin
            logic [POWER_WIDTH-1:0] want;
            want = pending_power.pop_front();
            if (rsp_tdata[POWER_WIDTH-1:0] !== want) begin
               $error("power_value: expected %h actual %h", want,
                      rsp_tdata[POWER_WIDTH-1:0]);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL fixed_point_exp2_unit");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Directed table: expected power typed in where it is obvious
   // (zero fraction is an exact power of two; integer part 0 always gives 1),
   // otherwise taken from the predictor.
   // ------------------------------------------------------------------
   typedef struct {
      logic [LOG_WIDTH-1:0]   log_value;
      bit                     has_power;
      logic [POWER_WIDTH-1:0] power_value;
   } dir_row_type;

   dir_row_type directed_rows [DIR_ROWS] = '{
      '{ {6'd0,  32'h0000_0000}, 1'b1, 64'd1 },
      '{ {6'd0,  32'hffff_ffff}, 1'b1, 64'd1 },
      '{ {6'd0,  32'h8000_0000}, 1'b1, 64'd1 },
      '{ {6'd1,  32'h0000_0000}, 1'b1, 64'd2 },
      '{ {6'd31, 32'h0000_0000}, 1'b1, 64'h0000_0000_8000_0000 },
      '{ {6'd32, 32'h0000_0000}, 1'b1, 64'h0000_0001_0000_0000 },
      '{ {6'd63, 32'h0000_0000}, 1'b1, 64'h8000_0000_0000_0000 },
      // largest input: top of both the fraction and the integer range
      '{ {6'd63, 32'hffff_ffff}, 1'b0, 64'd0 },
      '{ {6'd62, 32'hffff_ffff}, 1'b0, 64'd0 },
      // smallest nonzero fraction, where the polynomial wraps toward zero
      '{ {6'd32, 32'h0000_0001}, 1'b0, 64'd0 },
      '{ {6'd63, 32'h0000_0001}, 1'b0, 64'd0 },
      '{ {6'd32, 32'h8000_0000}, 1'b0, 64'd0 },
      '{ {6'd63, 32'h8000_0000}, 1'b0, 64'd0 },
      '{ {6'd40, 32'h5555_5555}, 1'b0, 64'd0 },
      '{ {6'd20, 32'haaaa_aaaa}, 1'b0, 64'd0 },
      '{ {6'd1,  32'hffff_ffff}, 1'b0, 64'd0 }
   };

   // random log value, biased toward the edges of both parts
   function automatic logic [LOG_WIDTH-1:0] random_log();
      logic [INT_WIDTH-1:0]     n;
      logic [FRACTION_BITS-1:0] frac;
      int unsigned              pick;
      n    = INT_WIDTH'($urandom_range(0, (1 << INT_WIDTH) - 1));
      frac = $urandom();
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            frac = '0;                       // exact powers of two
         end
         1: begin
            case ($urandom_range(0, 5))      // integer part at the shift edges
               0: n = INT_WIDTH'(0);
               1: n = INT_WIDTH'(1);
               2: n = INT_WIDTH'(31);
               3: n = INT_WIDTH'(32);
               4: n = INT_WIDTH'(62);
               default: n = INT_WIDTH'(63);
            endcase
         end
         2: begin
            case ($urandom_range(0, 2))      // fraction extremes
               0: frac = '1;
               1: frac = 32'h0000_0001;
               default: frac = 32'h8000_0000;
            endcase
         end
         default: begin
         end
      endcase
      return {n, frac};
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [LOG_WIDTH-1:0] log_value;
      int unsigned          drain_wait;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // phase 0 idling: sender 11%, receiver 60%
      req_idle_pct = 11;
      rsp_idle_pct = 60;

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (directed_rows[r].has_power)
            send_log(directed_rows[r].log_value, directed_rows[r].power_value);
         else
            send_log(directed_rows[r].log_value, exp2_power(directed_rows[r].log_value));
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 11;
               rsp_idle_pct = 60;
            end
            1: begin
               req_idle_pct = 60;
               rsp_idle_pct = 11;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            log_value = random_log();
            send_log(log_value, exp2_power(log_value));
         end
         // sender holds off until the pipe is empty between phases
         drain_pipe();
      end

      // bounded wait for any stray output after the last result
      drain_wait = 0;
      while (pending_power.size() != 0 && drain_wait < CYCLE_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_power.size() == 0)
         $display("PASS fixed_point_exp2_unit");
      else
         $display("FAIL fixed_point_exp2_unit");
      $finish;
   end

endmodule
